@@ hw/rtl/rlim_pkg.sv @@
`default_nettype none

package rlim_pkg;

   localparam int CONNS_DEF      = 16;
   localparam int RING_DEPTH_DEF = 1024;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_LIMIT_ENABLE   = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_PER_WINDOW = 4'h4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_WINDOW_TICKS   = 4'h8;

   localparam logic        LIMIT_ENABLE_RST   = 1'b0;
   localparam logic [9:0]  MAX_PER_WINDOW_RST = 10'd500;
   localparam logic [30:0] WINDOW_TICKS_RST   = 31'd1000000;

   typedef struct packed {
      logic [3:0]  conn_index;
      logic [31:0] arrival_time;
   } req_type;

   typedef struct packed {
      logic        pass;
      logic [10:0] window_count;
   } rsp_type;

   typedef struct packed {
      logic        limit_enable;
      logic [9:0]  max_per_window;
      logic [30:0] window_ticks;
   } cfg_type;

endpackage

`default_nettype wire

@@ hw/rtl/rlim_csr.sv @@
`default_nettype none

module rlim_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [rlim_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [rlim_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [rlim_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready,
   output rlim_pkg::cfg_type                        cfg
);

   rlim_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr)
            rlim_pkg::ADDR_LIMIT_ENABLE:   cfg_in.limit_enable   = csr_pwdata[0];
            rlim_pkg::ADDR_MAX_PER_WINDOW: cfg_in.max_per_window = csr_pwdata[9:0];
            rlim_pkg::ADDR_WINDOW_TICKS:   cfg_in.window_ticks   = csr_pwdata[30:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         rlim_pkg::ADDR_LIMIT_ENABLE:   csr_prdata = {31'd0, cfg_ff.limit_enable};
         rlim_pkg::ADDR_MAX_PER_WINDOW: csr_prdata = {22'd0, cfg_ff.max_per_window};
         rlim_pkg::ADDR_WINDOW_TICKS:   csr_prdata = {1'b0, cfg_ff.window_ticks};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_enable   <= rlim_pkg::LIMIT_ENABLE_RST;
         cfg_ff.max_per_window <= rlim_pkg::MAX_PER_WINDOW_RST;
         cfg_ff.window_ticks   <= rlim_pkg::WINDOW_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rlim_mem.sv @@
`default_nettype none

module rlim_mem #(
   parameter int CONNS      = rlim_pkg::CONNS_DEF,
   parameter int RING_DEPTH = rlim_pkg::RING_DEPTH_DEF,
   localparam int CIW = (CONNS > 1) ? $clog2(CONNS) : 1,
   localparam int HW  = $clog2(RING_DEPTH),
   localparam int CW  = $clog2(RING_DEPTH + 1)
) (
   input  wire logic           clock,
   input  wire logic           ptr_rd_en,
   input  wire logic [CIW-1:0] ptr_rd_addr,
   output logic      [HW-1:0]  ptr_rd_head,
   output logic      [CW-1:0]  ptr_rd_count,
   input  wire logic           ptr_wr_en,
   input  wire logic [CIW-1:0] ptr_wr_addr,
   input  wire logic [HW-1:0]  ptr_wr_head,
   input  wire logic [CW-1:0]  ptr_wr_count,
   input  wire logic           stamp_rd_en,
   input  wire logic [CIW-1:0] stamp_rd_conn,
   input  wire logic [HW-1:0]  stamp_rd_pos,
   output logic      [31:0]    stamp_rd_data,
   input  wire logic           stamp_wr_en,
   input  wire logic [CIW-1:0] stamp_wr_conn,
   input  wire logic [HW-1:0]  stamp_wr_pos,
   input  wire logic [31:0]    stamp_wr_data
);

   logic [31:0]       stamp_mem_ff [CONNS][RING_DEPTH];
   logic [HW+CW-1:0]  ptr_mem_ff [CONNS];
   logic [31:0]       stamp_rd_ff;
   logic [HW+CW-1:0]  ptr_rd_ff;

   always_ff @(posedge clock) begin
      if (stamp_wr_en) begin
         stamp_mem_ff[stamp_wr_conn][stamp_wr_pos] <= stamp_wr_data;
      end
      if (stamp_rd_en) begin
         stamp_rd_ff <= stamp_mem_ff[stamp_rd_conn][stamp_rd_pos];
      end
   end

   always_ff @(posedge clock) begin
      if (ptr_wr_en) begin
         ptr_mem_ff[ptr_wr_addr] <= {ptr_wr_head, ptr_wr_count};
      end
      if (ptr_rd_en) begin
         ptr_rd_ff <= ptr_mem_ff[ptr_rd_addr];
      end
   end

   assign stamp_rd_data = stamp_rd_ff;
   assign ptr_rd_head   = ptr_rd_ff[HW+CW-1:CW];
   assign ptr_rd_count  = ptr_rd_ff[CW-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/rlim_ctrl.sv @@
`default_nettype none

module rlim_ctrl #(
   parameter int CONNS      = rlim_pkg::CONNS_DEF,
   parameter int RING_DEPTH = rlim_pkg::RING_DEPTH_DEF,
   localparam int CIW = (CONNS > 1) ? $clog2(CONNS) : 1,
   localparam int HW  = $clog2(RING_DEPTH),
   localparam int CW  = $clog2(RING_DEPTH + 1),
   localparam int SW  = CW + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rlim_pkg::cfg_type cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rlim_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rlim_pkg::rsp_type      rsp_payload,
   output logic                   ptr_rd_en,
   output logic      [CIW-1:0]    ptr_rd_addr,
   input  wire logic [HW-1:0]     ptr_rd_head,
   input  wire logic [CW-1:0]     ptr_rd_count,
   output logic                   ptr_wr_en,
   output logic      [CIW-1:0]    ptr_wr_addr,
   output logic      [HW-1:0]     ptr_wr_head,
   output logic      [CW-1:0]     ptr_wr_count,
   output logic                   stamp_rd_en,
   output logic      [CIW-1:0]    stamp_rd_conn,
   output logic      [HW-1:0]     stamp_rd_pos,
   input  wire logic [31:0]       stamp_rd_data,
   output logic                   stamp_wr_en,
   output logic      [CIW-1:0]    stamp_wr_conn,
   output logic      [HW-1:0]     stamp_wr_pos,
   output logic      [31:0]       stamp_wr_data
);

   localparam logic [2:0] S_SWEEP  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_PTR    = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [CIW-1:0] sweep_ff, sweep_in;
   logic [CIW-1:0] conn_ff, conn_in;
   logic           in_range_ff, in_range_in;
   logic [31:0]    now_ff, now_in;
   logic [HW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_pass_ff, rsp_pass_in;
   logic [10:0]    rsp_count_ff, rsp_count_in;

   logic           active;
   logic           out_free;
   logic           req_in_range;
   logic [HW-1:0]  head_inc;
   logic [SW-1:0]  slot_sum;
   logic [HW-1:0]  slot;
   logic [31:0]    age;
   logic           expired;
   logic           drop;

   assign active       = cfg.limit_enable && (cfg.max_per_window != 10'd0);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_in_range = 32'(req_payload.conn_index) < CONNS;
   assign head_inc     = (head_ff == HW'(RING_DEPTH - 1)) ? '0 : head_ff + HW'(1);
   assign slot_sum     = SW'(head_ff) + SW'(count_ff);
   assign slot         = (slot_sum >= SW'(RING_DEPTH)) ?
                         HW'(slot_sum - SW'(RING_DEPTH)) : HW'(slot_sum);
   assign age          = now_ff - stamp_rd_data;
   assign expired      = age > {1'b0, cfg.window_ticks};
   assign drop         = (32'(count_ff) > 32'(cfg.max_per_window)) ||
                         (32'(count_ff) >= RING_DEPTH);

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = '{pass: rsp_pass_ff, window_count: rsp_count_ff};
   assign ptr_rd_addr   = CIW'(req_payload.conn_index);
   assign stamp_rd_conn = conn_ff;
   assign stamp_wr_conn = conn_ff;
   assign stamp_wr_pos  = slot;
   assign stamp_wr_data = now_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      conn_in      = conn_ff;
      in_range_in  = in_range_ff;
      now_in       = now_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pass_in  = rsp_pass_ff;
      rsp_count_in = rsp_count_ff;
      ptr_rd_en    = 1'b0;
      ptr_wr_en    = 1'b0;
      ptr_wr_addr  = conn_ff;
      ptr_wr_head  = head_ff;
      ptr_wr_count = count_ff;
      stamp_rd_en  = 1'b0;
      stamp_rd_pos = head_ff;
      stamp_wr_en  = 1'b0;

      unique case (state_ff)
         S_SWEEP: begin
            ptr_wr_en    = 1'b1;
            ptr_wr_addr  = sweep_ff;
            ptr_wr_head  = '0;
            ptr_wr_count = '0;
            if (sweep_ff == CIW'(CONNS - 1)) begin
               state_in = S_IDLE;
            end else begin
               sweep_in = sweep_ff + CIW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               conn_in     = CIW'(req_payload.conn_index);
               now_in      = req_payload.arrival_time;
               in_range_in = req_in_range;
               ptr_rd_en   = req_in_range;
               state_in    = S_PTR;
            end
         end
         S_PTR: begin
            if (!in_range_ff || !active) begin
               // pass untouched
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_pass_in  = 1'b1;
                  rsp_count_in = in_range_ff ? 11'(ptr_rd_count) : 11'd0;
                  state_in     = S_IDLE;
               end
            end else begin
               head_in  = ptr_rd_head;
               count_in = ptr_rd_count;
               if (ptr_rd_count == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  stamp_rd_en  = 1'b1;
                  stamp_rd_pos = ptr_rd_head;
                  state_in     = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (expired) begin
               // pop oldest, fetch the next one if any remain
               head_in  = head_inc;
               count_in = count_ff - CW'(1);
               if (count_ff != CW'(1)) begin
                  stamp_rd_en  = 1'b1;
                  stamp_rd_pos = head_inc;
               end else begin
                  state_in = S_DECIDE;
               end
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (out_free) begin
               stamp_wr_en  = !drop;
               ptr_wr_en    = 1'b1;
               ptr_wr_count = drop ? count_ff : count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               rsp_pass_in  = !drop;
               rsp_count_in = 11'(ptr_wr_count);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      conn_ff      <= conn_in;
      in_range_ff  <= in_range_in;
      now_ff       <= now_in;
      head_ff      <= head_in;
      count_ff     <= count_in;
      rsp_pass_ff  <= rsp_pass_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/per_connection_sliding_window_limiter.sv @@
// A beat is accepted while idle and its connection's head and count are read; with limiting
// active, stored entries are then examined oldest first, expired ones popped until one stays
// or none are left, before the verdict is registered. One beat at a time, taken the cycle
// after the result is registered; hold while an earlier result waits.
// Reset: synchronous; a clearing pass then zeroes the per-connection head and count
// memory, during which no beat is accepted. Timestamp ring is not cleared.
`default_nettype none

module per_connection_sliding_window_limiter #(
   parameter int CONNS      = rlim_pkg::CONNS_DEF,
   parameter int RING_DEPTH = rlim_pkg::RING_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire rlim_pkg::req_type               req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output rlim_pkg::rsp_type                    rsp_payload,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rlim_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [rlim_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [rlim_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);

   localparam int CIW = (CONNS > 1) ? $clog2(CONNS) : 1;
   localparam int HW  = $clog2(RING_DEPTH);
   localparam int CW  = $clog2(RING_DEPTH + 1);

   rlim_pkg::cfg_type cfg;

   logic           ptr_rd_en;
   logic [CIW-1:0] ptr_rd_addr;
   logic [HW-1:0]  ptr_rd_head;
   logic [CW-1:0]  ptr_rd_count;
   logic           ptr_wr_en;
   logic [CIW-1:0] ptr_wr_addr;
   logic [HW-1:0]  ptr_wr_head;
   logic [CW-1:0]  ptr_wr_count;
   logic           stamp_rd_en;
   logic [CIW-1:0] stamp_rd_conn;
   logic [HW-1:0]  stamp_rd_pos;
   logic [31:0]    stamp_rd_data;
   logic           stamp_wr_en;
   logic [CIW-1:0] stamp_wr_conn;
   logic [HW-1:0]  stamp_wr_pos;
   logic [31:0]    stamp_wr_data;

   rlim_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rlim_mem #(
      .CONNS      (CONNS),
      .RING_DEPTH (RING_DEPTH)
   ) u_mem (
      .clock         (clock),
      .ptr_rd_en     (ptr_rd_en),
      .ptr_rd_addr   (ptr_rd_addr),
      .ptr_rd_head   (ptr_rd_head),
      .ptr_rd_count  (ptr_rd_count),
      .ptr_wr_en     (ptr_wr_en),
      .ptr_wr_addr   (ptr_wr_addr),
      .ptr_wr_head   (ptr_wr_head),
      .ptr_wr_count  (ptr_wr_count),
      .stamp_rd_en   (stamp_rd_en),
      .stamp_rd_conn (stamp_rd_conn),
      .stamp_rd_pos  (stamp_rd_pos),
      .stamp_rd_data (stamp_rd_data),
      .stamp_wr_en   (stamp_wr_en),
      .stamp_wr_conn (stamp_wr_conn),
      .stamp_wr_pos  (stamp_wr_pos),
      .stamp_wr_data (stamp_wr_data)
   );

   rlim_ctrl #(
      .CONNS      (CONNS),
      .RING_DEPTH (RING_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .ptr_rd_en     (ptr_rd_en),
      .ptr_rd_addr   (ptr_rd_addr),
      .ptr_rd_head   (ptr_rd_head),
      .ptr_rd_count  (ptr_rd_count),
      .ptr_wr_en     (ptr_wr_en),
      .ptr_wr_addr   (ptr_wr_addr),
      .ptr_wr_head   (ptr_wr_head),
      .ptr_wr_count  (ptr_wr_count),
      .stamp_rd_en   (stamp_rd_en),
      .stamp_rd_conn (stamp_rd_conn),
      .stamp_rd_pos  (stamp_rd_pos),
      .stamp_rd_data (stamp_rd_data),
      .stamp_wr_en   (stamp_wr_en),
      .stamp_wr_conn (stamp_wr_conn),
      .stamp_wr_pos  (stamp_wr_pos),
      .stamp_wr_data (stamp_wr_data)
   );

endmodule

`default_nettype wire

@@ bench/tb_per_connection_sliding_window_limiter.sv @@
`timescale 1ns / 1ps

module tb_per_connection_sliding_window_limiter;

   localparam int NCONN = rlim_pkg::CONNS_DEF;
   localparam int SLOTS = rlim_pkg::RING_DEPTH_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid = 1'b0;
   logic                            req_ready;
   rlim_pkg::req_type               req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   rlim_pkg::rsp_type               rsp_payload;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [rlim_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [rlim_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [rlim_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   per_connection_sliding_window_limiter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow of the limiter state and its registers
   logic [31:0] stamp_log [NCONN][SLOTS];
   logic [9:0]  log_head [NCONN];
   logic [10:0] log_count [NCONN];
   logic        lim_on = rlim_pkg::LIMIT_ENABLE_RST;
   logic [9:0]  lim_max = rlim_pkg::MAX_PER_WINDOW_RST;
   logic [30:0] lim_window = rlim_pkg::WINDOW_TICKS_RST;

   rlim_pkg::req_type pending_msgs [$];
   rlim_pkg::rsp_type verdict_q [$];
   int      mismatches = 0;
   logic    req_taken = 1'b0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      hold_asks = 0;
   int      hold_done = 0;
   int      hold_left = 0;
   int      stall_tick = 0;
   logic [15:0] stall_mask = '1;

   initial begin
      for (int c = 0; c < NCONN; c++) begin
         log_head[c] = '0;
         log_count[c] = '0;
      end
   end

   function automatic rlim_pkg::rsp_type admit_message(rlim_pkg::req_type m);
      int unsigned       c;
      rlim_pkg::rsp_type r;
      c = 32'(m.conn_index);
      r.pass = 1'b1;
      r.window_count = '0;
      if (c >= NCONN) return r;
      if (lim_on && lim_max != 0) begin
         while (log_count[c] != 0 &&
                32'(m.arrival_time - stamp_log[c][log_head[c]]) > {1'b0, lim_window}) begin
            log_head[c] = log_head[c] + 10'd1;
            log_count[c] = log_count[c] - 11'd1;
         end
         if (log_count[c] > lim_max || log_count[c] >= SLOTS) begin
            r.pass = 1'b0;
         end else begin
            stamp_log[c][10'(log_head[c] + log_count[c])] = m.arrival_time;
            log_count[c] = log_count[c] + 11'd1;
         end
      end
      r.window_count = log_count[c];
      return r;
   endfunction

   // accept on the request side, check on the result side
   always @(posedge clock) begin
      rlim_pkg::rsp_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) verdict_q = {verdict_q, admit_message(req_payload)};
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected result beat: pass %0d window_count %0d",
                      rsp_payload.pass, rsp_payload.window_count);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_payload.pass !== want.pass) begin
                  $error("pass: expected %0d, got %0d", want.pass, rsp_payload.pass);
                  mismatches++;
               end
               if (rsp_payload.window_count !== want.window_count) begin
                  $error("window_count: expected %0d, got %0d",
                         want.window_count, rsp_payload.window_count);
                  mismatches++;
               end
            end
         end
      end
   end

   // sender: bursts with gaps between them
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_msgs.size() != 0) begin
            req_payload <= pending_msgs.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: rotating stall mask, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_done != hold_asks) begin
         hold_done = hold_asks;
         hold_left = 400;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_tick == 0) begin
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
            stall_tick = 64;
         end
         stall_tick--;
         rsp_ready <= stall_mask[stall_tick % 16];
      end
   end

   task automatic csr_write(input logic [rlim_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_limit(input logic [rlim_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] value);
      csr_write(addr, value);
      unique case (addr)
         rlim_pkg::ADDR_LIMIT_ENABLE:   lim_on = value[0];
         rlim_pkg::ADDR_MAX_PER_WINDOW: lim_max = value[9:0];
         rlim_pkg::ADDR_WINDOW_TICKS:   lim_window = value[30:0];
         default: ;
      endcase
   endtask

   task automatic apply_limits(input logic en, input logic [9:0] max, input logic [30:0] win);
      set_limit(rlim_pkg::ADDR_LIMIT_ENABLE, {31'd0, en});
      set_limit(rlim_pkg::ADDR_MAX_PER_WINDOW, {22'd0, max});
      set_limit(rlim_pkg::ADDR_WINDOW_TICKS, {1'b0, win});
   endtask

   task automatic queue_msg(input logic [3:0] conn, input logic [31:0] stamp);
      rlim_pkg::req_type m;
      m.conn_index = conn;
      m.arrival_time = stamp;
      pending_msgs = {pending_msgs, m};
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_msgs.size() != 0 || req_valid || verdict_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_phase(input int n, inout logic [31:0] now_tick, input logic hold);
      logic [3:0]  hot [3];
      logic [9:0]  max;
      logic [30:0] win;
      logic [31:0] span;
      int          pick;
      logic        en;
      en = ($urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) max = 10'($urandom_range(1, 6));
      else if (pick == 7) max = 10'd0;
      else if (pick == 8) max = 10'd1023;
      else max = 10'($urandom_range(0, 1023));
      pick = $urandom_range(0, 9);
      if (pick < 6) win = 31'($urandom_range(8, 300));
      else if (pick < 8) win = 31'($urandom_range(1, 32'h7FFF_FFFF));
      else if (pick == 8) win = 31'd1;
      else win = 31'($urandom_range(1000, 100000));
      apply_limits(en, max, win);
      span = 32'((64'(win) * 2) / (64'(max) + 1));
      for (int k = 0; k < 3; k++) hot[k] = 4'($urandom_range(0, NCONN - 1));
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            queue_msg(4'($urandom_range(0, 15)), $urandom);
         end else begin
            if (pick < 5) now_tick = now_tick + $urandom;
            else now_tick = now_tick + $urandom_range(0, span);
            queue_msg((pick < 15) ? 4'($urandom_range(0, 15)) : hot[$urandom_range(0, 2)],
                      now_tick);
         end
      end
      if (hold) hold_asks++;
      wait_drained();
   endtask

   initial begin
      logic [31:0] now_tick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // limiting off after reset
      queue_msg(4'd0, 32'h0000_0000);
      queue_msg(4'd15, 32'hFFFF_FFFF);
      queue_msg(4'd7, 32'h0000_1234);
      wait_drained();

      // enable with the reset-time maximum and window
      set_limit(rlim_pkg::ADDR_LIMIT_ENABLE, 32'd1);
      queue_msg(4'd5, 32'd100);
      queue_msg(4'd5, 32'd200);
      wait_drained();

      // small maximum, window straddling the timestamp wrap
      apply_limits(1'b1, 10'd2, 31'd100);
      queue_msg(4'd15, 32'hFFFF_FFC0);
      queue_msg(4'd15, 32'hFFFF_FFD0);
      queue_msg(4'd15, 32'hFFFF_FFE0);
      queue_msg(4'd15, 32'hFFFF_FFF0);
      queue_msg(4'd15, 32'h0000_0010);
      queue_msg(4'd15, 32'h0000_0030);
      queue_msg(4'd15, 32'h0000_2000);
      queue_msg(4'd0, 32'h0000_0000);
      wait_drained();

      // disabled: stored entries stay
      set_limit(rlim_pkg::ADDR_LIMIT_ENABLE, 32'd0);
      queue_msg(4'd15, 32'h5555_AAAA);
      wait_drained();

      // zero maximum also passes everything
      apply_limits(1'b1, 10'd0, 31'd100);
      queue_msg(4'd15, 32'h0000_2001);
      wait_drained();

      // largest maximum and window
      apply_limits(1'b1, 10'd1023, 31'h7FFF_FFFF);
      queue_msg(4'd15, 32'h0000_2001);
      queue_msg(4'd3, 32'h8000_0000);
      queue_msg(4'd3, 32'h0000_0000);
      wait_drained();

      // zero window: only identical timestamps survive
      apply_limits(1'b1, 10'd3, 31'd0);
      queue_msg(4'd15, 32'h0000_2001);
      queue_msg(4'd15, 32'h0000_2001);
      queue_msg(4'd15, 32'h0000_2002);
      wait_drained();

      now_tick = $urandom;
      for (int p = 0; p < 12; p++) random_phase(152, now_tick, p == 3);

      repeat (40) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (verdict_q.size() != 0) $error("%0d results never arrived", verdict_q.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/rlim_pkg.sv
hw/rtl/rlim_csr.sv
hw/rtl/rlim_mem.sv
hw/rtl/rlim_ctrl.sv
hw/rtl/per_connection_sliding_window_limiter.sv
bench/tb_per_connection_sliding_window_limiter.sv
